@@ hdl/assert_macros.svh @@
// Assertion macros used by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BLM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BLM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/blm_pkg.sv @@
package blm_pkg;

   localparam int COUNT_W    = 32;
   localparam int VALUE_W    = 16;
   localparam int INTERVAL_W = 16;
   localparam int IDX_W      = 8;
   localparam int STORED_W   = 7;

   localparam int DEF_HISTORY_DEPTH   = 64;
   localparam int DEF_OCTET_BIT_TIMES = 13;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [VALUE_W-1:0]    VALUE_MAX      = 16'hFFFF;

   localparam int RATE_SCALE      = 1000;
   localparam int LOAD_SCALE      = 625;
   localparam int LOAD_TIME_SCALE = 6;

   localparam int DIV_W = COUNT_W + $clog2(LOAD_TIME_SCALE + 1);

endpackage

@@ hdl/blm_req_if.sv @@
interface blm_req_if;
   import blm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [COUNT_W-1:0]   now_ms;
   logic [COUNT_W-1:0]   frame_bits;
   logic [COUNT_W-1:0]   bus_bytes;
   logic [COUNT_W-1:0]   discarded_bytes;
   logic [IDX_W-1:0]     history_index;

   modport source (
      output valid, mode, now_ms, frame_bits, bus_bytes, discarded_bytes, history_index,
      input  ready
   );

   modport sink (
      input  valid, mode, now_ms, frame_bits, bus_bytes, discarded_bytes, history_index,
      output ready
   );

endinterface

@@ hdl/blm_rsp_if.sv @@
interface blm_rsp_if;
   import blm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 updated;
   logic [VALUE_W-1:0]   load_permille;
   logic [VALUE_W-1:0]   peak_permille;
   logic [VALUE_W-1:0]   bytes_per_second;
   logic [VALUE_W-1:0]   peak_bytes_per_second;
   logic [VALUE_W-1:0]   average_permille;
   logic [STORED_W-1:0]  samples_stored;
   logic [VALUE_W-1:0]   history_value;

   modport source (
      output valid, updated, load_permille, peak_permille, bytes_per_second,
             peak_bytes_per_second, average_permille, samples_stored, history_value,
      input  ready
   );

   modport sink (
      input  valid, updated, load_permille, peak_permille, bytes_per_second,
             peak_bytes_per_second, average_permille, samples_stored, history_value,
      output ready
   );

endinterface

@@ hdl/blm_ram.sv @@
module blm_ram #(
   parameter int WIDTH = blm_pkg::VALUE_W,
   parameter int DEPTH = blm_pkg::DEF_HISTORY_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bus_load_meter_unit.sv @@
// A measured sample is decoded, multiplied over the 13 bits of the larger scale constant,
// divided over the 46 numerator bits, pushed into the history, averaged over the 23 history
// sum bits and read back before the result loads. Clear, ignored and re-arm words go from
// decode straight to the history read. One word is in work at a time; back to back, the next
// word is taken the cycle after the result loads. Reset is synchronous: it clears all
// statistics, disarms and loads the interval with 1000; the fill count marks stored entries.
`include "assert_macros.svh"

module bus_load_meter_unit #(
   parameter int HISTORY_DEPTH   = blm_pkg::DEF_HISTORY_DEPTH,
   parameter int OCTET_BIT_TIMES = blm_pkg::DEF_OCTET_BIT_TIMES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [blm_pkg::INTERVAL_W-1:0]  csr_write_data,
   blm_req_if.sink                         req_bus,
   blm_rsp_if.source                       rsp_bus
);
   import blm_pkg::*;

   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W  = VALUE_W + FILL_W;
   localparam int DISC_K = OCTET_BIT_TIMES * LOAD_SCALE;
   localparam int NUM_W  = COUNT_W + $clog2(LOAD_SCALE + DISC_K + 1);
   localparam int K_W    = ($clog2(DISC_K + 1) > $clog2(RATE_SCALE + 1)) ?
                           $clog2(DISC_K + 1) : $clog2(RATE_SCALE + 1);
   localparam int KIDX_W = $clog2(K_W);
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int RD_W   = IDX_W + 1;
   localparam int EXT_W  = FILL_W + STORED_W;

   localparam logic [K_W-1:0] K_RATE = K_W'(RATE_SCALE);
   localparam logic [K_W-1:0] K_BITS = K_W'(LOAD_SCALE);
   localparam logic [K_W-1:0] K_DISC = K_W'(DISC_K);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_PUSH   = 4'd4;
   localparam logic [3:0] S_AVG    = 4'd5;
   localparam logic [3:0] S_READ   = 4'd6;
   localparam logic [3:0] S_RWAIT  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   // Control state.
   logic [3:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic                  armed_ff, armed_in;
   logic [VALUE_W-1:0]    load_now_ff, load_now_in;
   logic [VALUE_W-1:0]    load_peak_ff, load_peak_in;
   logic [VALUE_W-1:0]    rate_now_ff, rate_now_in;
   logic [VALUE_W-1:0]    rate_peak_ff, rate_peak_in;
   logic [VALUE_W-1:0]    avg_ff, avg_in;
   logic [POS_W-1:0]      wpos_ff, wpos_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload and datapath registers.
   logic [COUNT_W-1:0]    last_time_ff, last_time_in;
   logic [COUNT_W-1:0]    last_fb_ff, last_fb_in;
   logic [COUNT_W-1:0]    last_bb_ff, last_bb_in;
   logic [COUNT_W-1:0]    last_db_ff, last_db_in;
   logic                  mode_ff, mode_in;
   logic [COUNT_W-1:0]    now_ff, now_in;
   logic [COUNT_W-1:0]    fb_ff, fb_in;
   logic [COUNT_W-1:0]    bb_ff, bb_in;
   logic [COUNT_W-1:0]    db_ff, db_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [COUNT_W-1:0]    dbytes_ff, dbytes_in;
   logic [COUNT_W-1:0]    dbits_ff, dbits_in;
   logic [COUNT_W-1:0]    ddisc_ff, ddisc_in;
   logic [NUM_W-1:0]      acc_ff [2];
   logic [NUM_W-1:0]      acc_in [2];
   logic [DIV_W-1:0]      rem_ff [2];
   logic [DIV_W-1:0]      rem_in [2];
   logic [DIV_W-1:0]      dvs_ff [2];
   logic [DIV_W-1:0]      dvs_in [2];
   logic [VALUE_W-1:0]    quo_ff [2];
   logic [VALUE_W-1:0]    quo_in [2];
   logic                  sat_ff [2];
   logic                  sat_in [2];
   logic [POS_W-1:0]      raddr_ff, raddr_in;
   logic                  hit_ff, hit_in;
   logic                  upd_ff, upd_in;

   logic                  rsp_updated_ff, rsp_updated_in;
   logic [VALUE_W-1:0]    rsp_load_ff, rsp_load_in;
   logic [VALUE_W-1:0]    rsp_load_peak_ff, rsp_load_peak_in;
   logic [VALUE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic [VALUE_W-1:0]    rsp_rate_peak_ff, rsp_rate_peak_in;
   logic [VALUE_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [STORED_W-1:0]   rsp_stored_ff, rsp_stored_in;
   logic [VALUE_W-1:0]    rsp_hist_ff, rsp_hist_in;

   // Combinational helpers.
   logic                  accept;
   logic [COUNT_W-1:0]    elapsed;
   logic                  backward;
   logic                  too_soon;
   logic                  full;
   logic [KIDX_W-1:0]     kbit;
   logic [NUM_W-1:0]      mul_rate;
   logic [NUM_W-1:0]      mul_load;
   logic [DIV_W:0]        trial [2];
   logic [DIV_W:0]        diff [2];
   logic                  ge [2];
   logic [DIV_W-1:0]      rem_step [2];
   logic [VALUE_W-1:0]    quo_step [2];
   logic [VALUE_W-1:0]    rate_val;
   logic [VALUE_W-1:0]    load_val;
   logic [SUM_W-1:0]      new_sum;
   logic [FILL_W-1:0]     new_fill;
   logic [POS_W-1:0]      wpos_next;
   logic [POS_W-1:0]      rd_start;
   logic [RD_W-1:0]       rd_sum;
   logic [RD_W-1:0]       rd_wrap;
   logic [EXT_W-1:0]      fill_ext;
   logic                  ram_we;
   logic [VALUE_W-1:0]    ram_rdata;

   blm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (load_val),
      .rd_addr (raddr_ff),
      .rd_data (ram_rdata)
   );

   assign accept  = req_bus.valid && req_bus.ready;
   assign elapsed = now_ff - last_time_ff;
   assign backward = (fb_ff < last_fb_ff) || (bb_ff < last_bb_ff) || (db_ff < last_db_ff);
   assign too_soon = armed_ff && (elapsed < COUNT_W'(interval_ff));
   assign full     = (fill_ff == FILL_W'(HISTORY_DEPTH));
   assign kbit     = cnt_ff[KIDX_W-1:0];

   // One constant bit per cycle, most significant first.
   assign mul_rate = {acc_ff[0][NUM_W-2:0], 1'b0}
                   + (K_RATE[kbit] ? NUM_W'(dbytes_ff) : NUM_W'(0));
   assign mul_load = {acc_ff[1][NUM_W-2:0], 1'b0}
                   + (K_BITS[kbit] ? NUM_W'(dbits_ff) : NUM_W'(0))
                   + (K_DISC[kbit] ? NUM_W'(ddisc_ff) : NUM_W'(0));

   // Restoring division, one quotient bit per cycle in each lane.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l]    = {rem_ff[l], acc_ff[l][NUM_W-1]};
         diff[l]     = trial[l] - {1'b0, dvs_ff[l]};
         ge[l]       = (trial[l] >= {1'b0, dvs_ff[l]});
         rem_step[l] = ge[l] ? diff[l][DIV_W-1:0] : trial[l][DIV_W-1:0];
         quo_step[l] = {quo_ff[l][VALUE_W-2:0], ge[l]};
      end
   end

   assign rate_val  = sat_ff[0] ? VALUE_MAX : quo_ff[0];
   assign load_val  = sat_ff[1] ? VALUE_MAX : quo_ff[1];
   assign new_sum   = sum_ff - (full ? SUM_W'(ram_rdata) : SUM_W'(0)) + SUM_W'(load_val);
   assign new_fill  = full ? fill_ff : fill_ff + FILL_W'(1);
   assign wpos_next = (wpos_ff == POS_W'(HISTORY_DEPTH - 1)) ? POS_W'(0) : wpos_ff + POS_W'(1);
   assign rd_start  = full ? wpos_ff : POS_W'(0);
   assign rd_sum    = RD_W'(idx_ff) + RD_W'(rd_start);
   assign rd_wrap   = (rd_sum >= RD_W'(HISTORY_DEPTH)) ? rd_sum - RD_W'(HISTORY_DEPTH) : rd_sum;
   assign fill_ext  = EXT_W'(fill_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      interval_in  = csr_write_en ? csr_write_data : interval_ff;
      armed_in     = armed_ff;
      load_now_in  = load_now_ff;
      load_peak_in = load_peak_ff;
      rate_now_in  = rate_now_ff;
      rate_peak_in = rate_peak_ff;
      avg_in       = avg_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      last_time_in = last_time_ff;
      last_fb_in   = last_fb_ff;
      last_bb_in   = last_bb_ff;
      last_db_in   = last_db_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      fb_in        = fb_ff;
      bb_in        = bb_ff;
      db_in        = db_ff;
      idx_in       = idx_ff;
      dbytes_in    = dbytes_ff;
      dbits_in     = dbits_ff;
      ddisc_in     = ddisc_ff;
      for (int l = 0; l < 2; l++) begin
         acc_in[l] = acc_ff[l];
         rem_in[l] = rem_ff[l];
         dvs_in[l] = dvs_ff[l];
         quo_in[l] = quo_ff[l];
         sat_in[l] = sat_ff[l];
      end
      raddr_in         = raddr_ff;
      hit_in           = hit_ff;
      upd_in           = upd_ff;
      ram_we           = 1'b0;
      rsp_updated_in   = rsp_updated_ff;
      rsp_load_in      = rsp_load_ff;
      rsp_load_peak_in = rsp_load_peak_ff;
      rsp_rate_in      = rsp_rate_ff;
      rsp_rate_peak_in = rsp_rate_peak_ff;
      rsp_avg_in       = rsp_avg_ff;
      rsp_stored_in    = rsp_stored_ff;
      rsp_hist_in      = rsp_hist_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_bus.mode;
               now_in   = req_bus.now_ms;
               fb_in    = req_bus.frame_bits;
               bb_in    = req_bus.bus_bytes;
               db_in    = req_bus.discarded_bytes;
               idx_in   = req_bus.history_index;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            upd_in   = 1'b0;
            state_in = S_READ;
            if (mode_ff) begin
               fill_in      = '0;
               wpos_in      = '0;
               sum_in       = '0;
               load_now_in  = '0;
               load_peak_in = '0;
               rate_now_in  = '0;
               rate_peak_in = '0;
               avg_in       = '0;
               armed_in     = 1'b0;
            end else if (!too_soon) begin
               armed_in     = 1'b1;
               last_time_in = now_ff;
               last_fb_in   = fb_ff;
               last_bb_in   = bb_ff;
               last_db_in   = db_ff;
               if (armed_ff && !backward && (elapsed != '0)) begin
                  dbytes_in = bb_ff - last_bb_ff;
                  dbits_in  = fb_ff - last_fb_ff;
                  ddisc_in  = db_ff - last_db_ff;
                  dvs_in[0] = DIV_W'(elapsed);
                  dvs_in[1] = DIV_W'(elapsed) * DIV_W'(LOAD_TIME_SCALE);
                  for (int l = 0; l < 2; l++) begin
                     acc_in[l] = '0;
                     rem_in[l] = '0;
                     quo_in[l] = '0;
                     sat_in[l] = 1'b0;
                  end
                  raddr_in = wpos_ff;
                  cnt_in   = CNT_W'(K_W - 1);
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            acc_in[0] = mul_rate;
            acc_in[1] = mul_load;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_DIV, S_AVG: begin
            for (int l = 0; l < 2; l++) begin
               acc_in[l] = {acc_ff[l][NUM_W-2:0], 1'b0};
               rem_in[l] = rem_step[l];
               quo_in[l] = quo_step[l];
               sat_in[l] = sat_ff[l] || quo_ff[l][VALUE_W-1];
            end
            if (cnt_ff == '0) begin
               if (state_ff == S_DIV) begin
                  state_in = S_PUSH;
               end else begin
                  avg_in   = quo_step[0];
                  state_in = S_READ;
               end
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_PUSH: begin
            rate_now_in  = rate_val;
            rate_peak_in = (rate_val > rate_peak_ff) ? rate_val : rate_peak_ff;
            load_now_in  = load_val;
            load_peak_in = (load_val > load_peak_ff) ? load_val : load_peak_ff;
            ram_we       = 1'b1;
            sum_in       = new_sum;
            fill_in      = new_fill;
            wpos_in      = wpos_next;
            upd_in       = 1'b1;
            // The running average reuses the rate lane of the divider.
            acc_in[0]    = {new_sum, {(NUM_W - SUM_W){1'b0}}};
            dvs_in[0]    = DIV_W'(new_fill);
            rem_in[0]    = '0;
            quo_in[0]    = '0;
            sat_in[0]    = 1'b0;
            cnt_in       = CNT_W'(SUM_W - 1);
            state_in     = S_AVG;
         end
         S_READ: begin
            hit_in   = RD_W'(idx_ff) < RD_W'(fill_ff);
            raddr_in = rd_wrap[POS_W-1:0];
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_updated_in   = upd_ff;
               rsp_load_in      = load_now_ff;
               rsp_load_peak_in = load_peak_ff;
               rsp_rate_in      = rate_now_ff;
               rsp_rate_peak_in = rate_peak_ff;
               rsp_avg_in       = avg_ff;
               rsp_stored_in    = fill_ext[STORED_W-1:0];
               rsp_hist_in      = hit_ff ? ram_rdata : VALUE_W'(0);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         interval_ff  <= INTERVAL_RESET;
         armed_ff     <= 1'b0;
         load_now_ff  <= '0;
         load_peak_ff <= '0;
         rate_now_ff  <= '0;
         rate_peak_ff <= '0;
         avg_ff       <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         interval_ff  <= interval_in;
         armed_ff     <= armed_in;
         load_now_ff  <= load_now_in;
         load_peak_ff <= load_peak_in;
         rate_now_ff  <= rate_now_in;
         rate_peak_ff <= rate_peak_in;
         avg_ff       <= avg_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_time_ff <= last_time_in;
      last_fb_ff   <= last_fb_in;
      last_bb_ff   <= last_bb_in;
      last_db_ff   <= last_db_in;
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      fb_ff        <= fb_in;
      bb_ff        <= bb_in;
      db_ff        <= db_in;
      idx_ff       <= idx_in;
      dbytes_ff    <= dbytes_in;
      dbits_ff     <= dbits_in;
      ddisc_ff     <= ddisc_in;
      for (int l = 0; l < 2; l++) begin
         acc_ff[l] <= acc_in[l];
         rem_ff[l] <= rem_in[l];
         dvs_ff[l] <= dvs_in[l];
         quo_ff[l] <= quo_in[l];
         sat_ff[l] <= sat_in[l];
      end
      raddr_ff         <= raddr_in;
      hit_ff           <= hit_in;
      upd_ff           <= upd_in;
      rsp_updated_ff   <= rsp_updated_in;
      rsp_load_ff      <= rsp_load_in;
      rsp_load_peak_ff <= rsp_load_peak_in;
      rsp_rate_ff      <= rsp_rate_in;
      rsp_rate_peak_ff <= rsp_rate_peak_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_stored_ff    <= rsp_stored_in;
      rsp_hist_ff      <= rsp_hist_in;
   end

   assign req_bus.ready                 = (state_ff == S_IDLE);
   assign rsp_bus.valid                 = rsp_valid_ff;
   assign rsp_bus.updated               = rsp_updated_ff;
   assign rsp_bus.load_permille         = rsp_load_ff;
   assign rsp_bus.peak_permille         = rsp_load_peak_ff;
   assign rsp_bus.bytes_per_second      = rsp_rate_ff;
   assign rsp_bus.peak_bytes_per_second = rsp_rate_peak_ff;
   assign rsp_bus.average_permille      = rsp_avg_ff;
   assign rsp_bus.samples_stored        = rsp_stored_ff;
   assign rsp_bus.history_value         = rsp_hist_ff;

   `BLM_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(HISTORY_DEPTH),
      "fill count above history depth")
   `BLM_ASSERT_IMPLIES(a_empty_sum, clock, reset, fill_ff == '0, sum_ff == '0,
      "history sum nonzero while empty")
   `BLM_ASSERT_ALWAYS(a_peaks, clock, reset,
      (load_peak_ff >= load_now_ff) && (rate_peak_ff >= rate_now_ff), "peak below current value")
   `BLM_ASSERT_ALWAYS(a_avg_peak, clock, reset, avg_ff <= load_peak_ff,
      "average above load peak")
   `BLM_ASSERT_NEXT(a_accept_decide, clock, reset, req_bus.valid && req_bus.ready,
      state_ff == S_DECIDE, "accepted word not decoded")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import blm_pkg::*;

   localparam int HIST_DEPTH = DEF_HISTORY_DEPTH;
   localparam int OCTET_BITS = DEF_OCTET_BIT_TIMES;

   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_CLEAR  = 1'b1
   } meter_mode_type;

   typedef struct packed {
      meter_mode_type       mode;
      logic [COUNT_W-1:0]   now_ms;
      logic [COUNT_W-1:0]   frame_bits;
      logic [COUNT_W-1:0]   bus_bytes;
      logic [COUNT_W-1:0]   discarded_bytes;
      logic [IDX_W-1:0]     history_index;
   } meter_word_type;

   typedef struct packed {
      logic                 updated;
      logic [VALUE_W-1:0]   load_permille;
      logic [VALUE_W-1:0]   peak_permille;
      logic [VALUE_W-1:0]   bytes_per_second;
      logic [VALUE_W-1:0]   peak_bytes_per_second;
      logic [VALUE_W-1:0]   average_permille;
      logic [STORED_W-1:0]  samples_stored;
      logic [VALUE_W-1:0]   history_value;
   } meter_report_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_en;
   logic [INTERVAL_W-1:0]   csr_write_data;

   blm_req_if req_bus ();
   blm_rsp_if rsp_bus ();

   bus_load_meter_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted meter state.
   logic [INTERVAL_W-1:0]   interval_ms = INTERVAL_RESET;
   logic                    is_armed    = 1'b0;
   logic [COUNT_W-1:0]      prev_ms     = '0;
   logic [COUNT_W-1:0]      prev_bits   = '0;
   logic [COUNT_W-1:0]      prev_bytes  = '0;
   logic [COUNT_W-1:0]      prev_disc   = '0;
   logic [VALUE_W-1:0]      cur_load    = '0;
   logic [VALUE_W-1:0]      top_load    = '0;
   logic [VALUE_W-1:0]      cur_rate    = '0;
   logic [VALUE_W-1:0]      top_rate    = '0;
   logic [VALUE_W-1:0]      load_hist [HIST_DEPTH];
   int unsigned             hist_wr     = 0;
   int unsigned             hist_cnt    = 0;
   int unsigned             hist_total  = 0;

   meter_word_type          pending_words [$];
   meter_report_type        expected_reports [$];
   meter_word_type          in_flight;
   meter_report_type        want;
   int unsigned             idle_pct;
   int unsigned             stall_pct;
   int unsigned             mismatches    = 0;
   int unsigned             words_sent    = 0;
   int unsigned             reports_seen  = 0;
   int unsigned             measured_cnt  = 0;
   int unsigned             clear_cnt     = 0;
   bit                      ring_wrapped  = 1'b0;

   logic [COUNT_W-1:0]      gen_ms;
   logic [COUNT_W-1:0]      gen_bits;
   logic [COUNT_W-1:0]      gen_bytes;
   logic [COUNT_W-1:0]      gen_disc;

   initial begin
      foreach (load_hist[i]) load_hist[i] = '0;
   end

   function automatic logic [VALUE_W-1:0] clip16(input longint unsigned v);
      return (v > 64'hFFFF) ? VALUE_MAX : v[VALUE_W-1:0];
   endfunction

   function automatic meter_report_type meter_predict(input meter_word_type w);
      meter_report_type   r;
      logic [COUNT_W-1:0] elapsed;
      longint unsigned    el64;
      longint unsigned    d_bits;
      longint unsigned    d_bytes;
      longint unsigned    d_disc;
      longint unsigned    occupied;
      int unsigned        start;
      r = '0;
      if (w.mode == MODE_CLEAR) begin
         foreach (load_hist[i]) load_hist[i] = '0;
         hist_wr = 0;
         hist_cnt = 0;
         hist_total = 0;
         cur_load = '0;
         top_load = '0;
         cur_rate = '0;
         top_rate = '0;
         is_armed = 1'b0;
         clear_cnt++;
      end else begin
         elapsed = w.now_ms - prev_ms;
         if (!is_armed || elapsed >= interval_ms) begin
            if (!is_armed || w.frame_bits < prev_bits || w.bus_bytes < prev_bytes ||
                w.discarded_bytes < prev_disc) begin
               is_armed = 1'b1;
            end else begin
               d_bits  = w.frame_bits - prev_bits;
               d_bytes = w.bus_bytes - prev_bytes;
               d_disc  = w.discarded_bytes - prev_disc;
               if (elapsed != 0) begin
                  el64 = elapsed;
                  cur_rate = clip16((d_bytes * RATE_SCALE) / el64);
                  if (cur_rate > top_rate) top_rate = cur_rate;
                  occupied = d_bits + d_disc * OCTET_BITS;
                  cur_load = clip16((occupied * LOAD_SCALE) / (LOAD_TIME_SCALE * el64));
                  if (hist_cnt >= HIST_DEPTH) begin
                     hist_total -= load_hist[hist_wr];
                     ring_wrapped = 1'b1;
                  end else begin
                     hist_cnt++;
                  end
                  load_hist[hist_wr] = cur_load;
                  hist_total += cur_load;
                  hist_wr = (hist_wr + 1) % HIST_DEPTH;
                  if (cur_load > top_load) top_load = cur_load;
                  r.updated = 1'b1;
                  measured_cnt++;
               end
            end
            prev_ms    = w.now_ms;
            prev_bits  = w.frame_bits;
            prev_bytes = w.bus_bytes;
            prev_disc  = w.discarded_bytes;
         end
      end
      r.load_permille         = cur_load;
      r.peak_permille         = top_load;
      r.bytes_per_second      = cur_rate;
      r.peak_bytes_per_second = top_rate;
      r.average_permille      = (hist_cnt != 0) ? VALUE_W'(hist_total / hist_cnt) : '0;
      r.samples_stored        = STORED_W'(hist_cnt);
      if (w.history_index < hist_cnt) begin
         start = (hist_cnt >= HIST_DEPTH) ? hist_wr : 0;
         r.history_value = load_hist[(start + w.history_index) % HIST_DEPTH];
      end
      return r;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_reports.push_back(meter_predict(in_flight));
            words_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               in_flight = pending_words.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.mode            <= in_flight.mode;
               req_bus.now_ms          <= in_flight.now_ms;
               req_bus.frame_bits      <= in_flight.frame_bits;
               req_bus.bus_bytes       <= in_flight.bus_bytes;
               req_bus.discarded_bytes <= in_flight.discarded_bytes;
               req_bus.history_index   <= in_flight.history_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $display("%0t: result word with no expectation, expected none, actual load %0d",
                     $time, rsp_bus.load_permille);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("updated", 32'(want.updated), 32'(rsp_bus.updated));
            check_field("load_permille", 32'(want.load_permille),
                        32'(rsp_bus.load_permille));
            check_field("peak_permille", 32'(want.peak_permille),
                        32'(rsp_bus.peak_permille));
            check_field("bytes_per_second", 32'(want.bytes_per_second),
                        32'(rsp_bus.bytes_per_second));
            check_field("peak_bytes_per_second", 32'(want.peak_bytes_per_second),
                        32'(rsp_bus.peak_bytes_per_second));
            check_field("average_permille", 32'(want.average_permille),
                        32'(rsp_bus.average_permille));
            check_field("samples_stored", 32'(want.samples_stored),
                        32'(rsp_bus.samples_stored));
            check_field("history_value", 32'(want.history_value),
                        32'(rsp_bus.history_value));
         end
      end
   end

   task automatic queue_word(input meter_mode_type m, input logic [COUNT_W-1:0] t, fb, bb, db,
                             input logic [IDX_W-1:0] idx);
      meter_word_type w;
      w.mode            = m;
      w.now_ms          = t;
      w.frame_bits      = fb;
      w.bus_bytes       = bb;
      w.discarded_bytes = db;
      w.history_index   = idx;
      pending_words.push_back(w);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_reports.size() != 0);
   endtask

   task automatic write_interval(input logic [INTERVAL_W-1:0] v);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      interval_ms = v;
      @(negedge clock);
   endtask

   // Mostly well-formed counter streams; a few clears, early words, rollbacks and noise.
   task automatic gen_stream(input int count);
      int unsigned        pick;
      int unsigned        step;
      int unsigned        span;
      logic [IDX_W-1:0]   idx;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         idx  = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(255))
                                         : IDX_W'($urandom_range(70));
         if (pick < 2) begin
            queue_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, idx);
         end else if (pick < 6) begin
            gen_ms    = $urandom;
            gen_bits  = $urandom;
            gen_bytes = $urandom;
            gen_disc  = $urandom;
            queue_word(MODE_SAMPLE, gen_ms, gen_bits, gen_bytes, gen_disc, idx);
         end else begin
            if (pick < 12 && interval_ms > 1)
               step = $urandom_range(interval_ms - 1);
            else if ($urandom_range(9) == 0)
               step = interval_ms + $urandom_range(100000);
            else
               step = interval_ms + $urandom_range(40);
            gen_ms += step;
            span = step * 12 + 1;
            if ($urandom_range(9) == 0) begin
               gen_bits  += $urandom;
               gen_bytes += $urandom;
               gen_disc  += $urandom;
            end else begin
               gen_bits  += $urandom_range(span);
               gen_bytes += $urandom_range(span / 10 + 1);
               gen_disc  += $urandom_range(span / 100 + 1);
            end
            if (pick >= 12 && pick < 17) begin
               case ($urandom_range(2))
                  0: gen_bits  -= 1 + $urandom_range(1000);
                  1: gen_bytes -= 1 + $urandom_range(1000);
                  default: gen_disc -= 1 + $urandom_range(1000);
               endcase
            end
            queue_word(MODE_SAMPLE, gen_ms, gen_bits, gen_bytes, gen_disc, idx);
         end
      end
   endtask

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] t0;
      int unsigned        phase_idle [4];
      int unsigned        phase_stall [4];
      logic [INTERVAL_W-1:0] phase_interval [4];

      reset                   = 1'b1;
      csr_write_en            = 1'b0;
      csr_write_data          = '0;
      idle_pct                = 0;
      stall_pct               = 0;
      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_SAMPLE;
      req_bus.now_ms          = '0;
      req_bus.frame_bits      = '0;
      req_bus.bus_bytes       = '0;
      req_bus.discarded_bytes = '0;
      req_bus.history_index   = '0;
      rsp_bus.ready           = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default interval: arm, early word, measure, rollback, saturation, idle bus, clear,
      // timestamp wrap with full-scale deltas.
      queue_word(MODE_SAMPLE, 32'd5, '0, '0, '0, 8'd0);
      queue_word(MODE_SAMPLE, 32'd500, 32'd100, 32'd10, 32'd1, 8'd0);
      queue_word(MODE_SAMPLE, 32'd1005, 32'd9600, 32'd960, 32'd10, 8'd0);
      queue_word(MODE_SAMPLE, 32'd2005, 32'd9700, 32'd900, 32'd10, 8'd1);
      queue_word(MODE_SAMPLE, 32'd3005, 32'h8000_0000, 32'd100900, 32'h0000_FFFF, 8'd1);
      queue_word(MODE_SAMPLE, 32'd4005, 32'h8000_0000, 32'd100900, 32'h0000_FFFF, 8'd255);
      queue_word(MODE_CLEAR, '1, '1, '1, '1, 8'd0);
      queue_word(MODE_SAMPLE, 32'hFFFF_FE00, '0, '0, '0, 8'd0);
      queue_word(MODE_SAMPLE, 32'h0000_0300, '1, '1, '1, 8'd0);
      queue_word(MODE_SAMPLE, 32'h0000_0800, '0, '0, '0, 8'd64);
      wait_quiet();

      // Zero interval accepts any spacing, including a repeated timestamp.
      t0 = 32'h1234_5678;
      write_interval('0);
      queue_word(MODE_SAMPLE, t0, 32'h100, 32'h100, 32'h100, 8'd0);
      queue_word(MODE_SAMPLE, t0, 32'h105, 32'h105, 32'h105, 8'd1);
      queue_word(MODE_SAMPLE, t0 + 1, 32'hF000_0000, 32'hF000_0000, 32'hF000_0000, 8'd2);
      wait_quiet();

      write_interval(16'hFFFF);
      queue_word(MODE_SAMPLE, t0 + 65534, 32'hF000_0000, 32'hF000_0000, 32'hF000_0000, 8'd3);
      queue_word(MODE_SAMPLE, t0 + 65536, 32'hF000_0000, 32'hF000_0000, 32'hF000_0000, 8'd3);
      wait_quiet();

      // One millisecond spacing: values just below and just above saturation.
      write_interval(16'd1);
      queue_word(MODE_SAMPLE, t0 + 65537, 32'hF000_0000 + 629, 32'hF000_0000 + 65,
                 32'hF000_0000, 8'd4);
      queue_word(MODE_SAMPLE, t0 + 65538, 32'hF000_0000 + 1259, 32'hF000_0000 + 131,
                 32'hF000_0000, 8'd255);
      queue_word(MODE_SAMPLE, t0 + 65538, 32'hF000_0000 + 1300, 32'hF000_0000 + 140,
                 32'hF000_0000, 8'd5);
      queue_word(MODE_CLEAR, '0, '0, '0, '0, 8'd0);
      queue_word(MODE_SAMPLE, t0 + 70000, 32'd1, 32'd1, 32'd1, 8'd0);
      wait_quiet();

      phase_idle     = '{0, 55, 0, 6};
      phase_stall    = '{0, 0, 55, 6};
      phase_interval = '{16'd1000, 16'd1, 16'hFFFF, INTERVAL_W'($urandom_range(2, 65534))};
      for (int p = 0; p < 4; p++) begin
         write_interval(phase_interval[p]);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         gen_ms    = $urandom;
         gen_bits  = $urandom;
         gen_bytes = $urandom;
         gen_disc  = $urandom;
         gen_stream(48);
         wait_quiet();
         gen_stream(48);
         wait_quiet();
      end

      repeat (100) @(posedge clock);
      $display("Sent %0d words and checked %0d results: %0d measured samples, %0d clears.",
               words_sent, reports_seen, measured_cnt, clear_cnt);
      $display("Intervals 0, 1, 1000, 65535 and one random value; history ring wrapped: %0d.",
               ring_wrapped);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
